[design/pra_pkg.sv]
package pra_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;
	localparam int ROTATION_STAGES = 16;

	localparam int ATAN_ENTRIES = 24;
	localparam int TURN_W = 32;
	localparam int TRIG_W = 32;
	localparam int TRIG_FRAC = 30;
	localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;
	localparam logic [TURN_W-1:0] EIGHTH_TURN = 32'h2000_0000;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z = 2'd2;

	// point minus origin, one bit wider than a coordinate
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int UA_W = (DIFF_W > 32) ? DIFF_W : 33;
	localparam int HI_W = UA_W - 32;
	localparam int UB_W = TRIG_W - 1;
	localparam int LO_W = 32 + UB_W;
	localparam int HP_W = HI_W + UB_W;
	localparam int RND_W = LO_W + 1 - TRIG_FRAC;
	localparam int MAG_W = (((HP_W + 2) > RND_W) ? (HP_W + 2) : RND_W) + 1;
	localparam int TERM_W = MAG_W + 1;
	localparam int SUM_W = TERM_W + 2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic [ANGLE_WIDTH-1:0] angle;
	} point_req_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rotated_x;
		logic signed [COORD_WIDTH-1:0] rotated_y;
		logic signed [COORD_WIDTH-1:0] rotated_z;
		logic saturated;
	} point_rsp_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dz;
		logic [COORD_WIDTH-1:0] py;
	} side_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [TURN_W-1:0] atan_turn(input int unsigned i);
		logic [TURN_W-1:0] r;
		case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [UA_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
		logic [DIFF_W-1:0] m;
		m = v[DIFF_W-1] ? (~v + 1'b1) : v;
		return UA_W'(m);
	endfunction

	function automatic logic [UB_W-1:0] abs_trig(input logic signed [TRIG_W-1:0] v);
		logic [TRIG_W-1:0] m;
		m = v[TRIG_W-1] ? (~v + 1'b1) : v;
		return m[UB_W-1:0];
	endfunction

endpackage

[design/pra_cordic.sv]
module pra_cordic #(
	parameter int STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [pra_pkg::ANGLE_WIDTH-1:0] in_angle,
	input  pra_pkg::side_t in_side,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [pra_pkg::TRIG_W-1:0] out_cos,
	output logic signed [pra_pkg::TRIG_W-1:0] out_sin,
	output pra_pkg::side_t out_side
);
	import pra_pkg::*;

	localparam int LAST = STAGES + 1;

	logic [LAST:0] v_s;
	logic [LAST:0] en;
	side_t side_s [0:LAST];
	logic [1:0] q_s [0:STAGES];
	logic signed [TURN_W-1:0] z_s [0:STAGES];
	logic signed [TRIG_W-1:0] c_s [1:STAGES];
	logic signed [TRIG_W-1:0] sn_s [1:STAGES];
	logic signed [TRIG_W-1:0] cq_s;
	logic signed [TRIG_W-1:0] sq_s;
	logic [TURN_W-1:0] turn;
	logic signed [TRIG_W-1:0] cq_d;
	logic signed [TRIG_W-1:0] sq_d;

	always_comb begin
		en[LAST] = ~v_s[LAST] | out_ready;
		for (int k = LAST - 1; k >= 0; k--) begin
			en[k] = ~v_s[k] | en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s[0] <= en[0] ? in_valid : v_s[0];
			for (int k = 1; k <= LAST; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	// quadrant split around the nearest axis, residual in [-1/8, 1/8) turn
	assign turn = {in_angle, {(TURN_W-ANGLE_WIDTH){1'b0}}} + EIGHTH_TURN;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s[0] <= turn[TURN_W-1 -: 2];
			z_s[0] <= $signed({2'b00, turn[TURN_W-3:0]}) - $signed(EIGHTH_TURN);
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_iter
		logic signed [TRIG_W-1:0] c_prev;
		logic signed [TRIG_W-1:0] s_prev;

		if (k == 0) begin : g_first
			assign c_prev = GAIN_Q30;
			assign s_prev = '0;
		end else begin : g_next
			assign c_prev = c_s[k];
			assign s_prev = sn_s[k];
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				if (!z_s[k][TURN_W-1]) begin
					c_s[k+1] <= c_prev - (s_prev >>> k);
					sn_s[k+1] <= s_prev + (c_prev >>> k);
					z_s[k+1] <= z_s[k] - $signed(atan_turn(k));
				end else begin
					c_s[k+1] <= c_prev + (s_prev >>> k);
					sn_s[k+1] <= s_prev - (c_prev >>> k);
					z_s[k+1] <= z_s[k] + $signed(atan_turn(k));
				end
				q_s[k+1] <= q_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_comb begin
		case (q_s[STAGES])
			2'd0: begin
				cq_d = c_s[STAGES];
				sq_d = sn_s[STAGES];
			end
			2'd1: begin
				cq_d = -sn_s[STAGES];
				sq_d = c_s[STAGES];
			end
			2'd2: begin
				cq_d = -c_s[STAGES];
				sq_d = -sn_s[STAGES];
			end
			default: begin
				cq_d = sn_s[STAGES];
				sq_d = -c_s[STAGES];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			cq_s <= cq_d;
			sq_s <= sq_d;
			side_s[LAST] <= side_s[STAGES];
		end
	end

	assign out_valid = v_s[LAST];
	assign out_cos = cq_s;
	assign out_sin = sq_s;
	assign out_side = side_s[LAST];

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s[0])
		else $error("accepted request did not enter the first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline blocked with empty output stage");

endmodule

[design/pra_rotate.sv]
module pra_rotate (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [pra_pkg::TRIG_W-1:0] in_cos,
	input  logic signed [pra_pkg::TRIG_W-1:0] in_sin,
	input  pra_pkg::side_t in_side,
	input  logic signed [pra_pkg::COORD_WIDTH-1:0] origin_x,
	input  logic signed [pra_pkg::COORD_WIDTH-1:0] origin_z,
	output logic out_valid,
	input  logic out_ready,
	output pra_pkg::point_rsp_t out_data
);
	import pra_pkg::*;

	localparam int CLIP_W = SUM_W - COORD_WIDTH + 1;
	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [UA_W-1:0] ua_s1 [2];
	logic [UB_W-1:0] ub_s1 [2];
	logic [1:0] sa_s1;
	logic [1:0] sb_s1;
	logic [COORD_WIDTH-1:0] py_s1, py_s2, py_s3, py_s4;

	logic [LO_W-1:0] lo_s2 [4];
	logic [HP_W-1:0] hi_s2 [4];
	logic [3:0] neg_s2;

	logic signed [TERM_W-1:0] term_s3 [4];

	logic signed [SUM_W-1:0] sx_s4;
	logic signed [SUM_W-1:0] sz_s4;

	point_rsp_t out_s5;

	logic [CLIP_W-1:0] top_x;
	logic [CLIP_W-1:0] top_z;
	logic clip_x;
	logic clip_z;
	point_rsp_t rsp_d;

	assign en5 = ~v_s5 | out_ready;
	assign en4 = ~v_s4 | en5;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// magnitudes and signs
	always_ff @(posedge clk) begin
		if (en1) begin
			ua_s1[0] <= abs_diff(in_side.dx);
			ua_s1[1] <= abs_diff(in_side.dz);
			ub_s1[0] <= abs_trig(in_cos);
			ub_s1[1] <= abs_trig(in_sin);
			sa_s1 <= {in_side.dz[DIFF_W-1], in_side.dx[DIFF_W-1]};
			sb_s1 <= {in_sin[TRIG_W-1], in_cos[TRIG_W-1]};
			py_s1 <= in_side.py;
		end
	end

	// products: dx*cos, dz*sin, dx*sin, dz*cos
	for (genvar k = 0; k < 4; k++) begin : g_prod
		localparam int AI = k % 2;
		localparam int BI = (k == 1 || k == 2) ? 1 : 0;
		logic [RND_W+TRIG_FRAC-1:0] rnd;
		logic [MAG_W-1:0] mag;

		always_ff @(posedge clk) begin
			if (en2) begin
				lo_s2[k] <= LO_W'(ua_s1[AI][31:0] * ub_s1[BI]);
				hi_s2[k] <= HP_W'(ua_s1[AI][UA_W-1:32] * ub_s1[BI]);
				neg_s2[k] <= sa_s1[AI] ^ sb_s1[BI];
			end
		end

		// half away from zero on the magnitude
		assign rnd = {1'b0, lo_s2[k]} + ((RND_W+TRIG_FRAC)'(1) << (TRIG_FRAC - 1));
		assign mag = MAG_W'({hi_s2[k], 2'b00}) + MAG_W'(rnd[RND_W+TRIG_FRAC-1:TRIG_FRAC]);

		always_ff @(posedge clk) begin
			if (en3) begin
				term_s3[k] <= neg_s2[k] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) py_s2 <= py_s1;
		if (en3) py_s3 <= py_s2;
		if (en4) begin
			sx_s4 <= SUM_W'(term_s3[0]) - SUM_W'(term_s3[1]) + SUM_W'(origin_x);
			sz_s4 <= SUM_W'(term_s3[2]) + SUM_W'(term_s3[3]) + SUM_W'(origin_z);
			py_s4 <= py_s3;
		end
	end

	assign top_x = sx_s4[SUM_W-1:COORD_WIDTH-1];
	assign top_z = sz_s4[SUM_W-1:COORD_WIDTH-1];
	assign clip_x = ~((&top_x) | ~(|top_x));
	assign clip_z = ~((&top_z) | ~(|top_z));

	always_comb begin
		rsp_d.rotated_x = clip_x ? (sx_s4[SUM_W-1] ? COORD_MIN : COORD_MAX)
			: sx_s4[COORD_WIDTH-1:0];
		rsp_d.rotated_y = py_s4;
		rsp_d.rotated_z = clip_z ? (sz_s4[SUM_W-1] ? COORD_MIN : COORD_MAX)
			: sz_s4[COORD_WIDTH-1:0];
		rsp_d.saturated = clip_x | clip_z;
	end

	always_ff @(posedge clk) begin
		if (en5) out_s5 <= rsp_d;
	end

	assign out_valid = v_s5;
	assign out_data = out_s5;

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline blocked with empty output stage");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			out_data.rotated_x == COORD_MAX || out_data.rotated_x == COORD_MIN ||
			out_data.rotated_z == COORD_MAX || out_data.rotated_z == COORD_MIN)
		else $error("saturated flag without a clipped coordinate");

endmodule

[design/point_rotate_about_y.sv]
// Rotation of a point about the vertical axis through the programmed origin.
// Each CORDIC step and multiply stage is its own register, between the input and output registers.
// Throughput: one request per cycle unless a stalled output holds the pipeline.
// A stalled output holds its result; empty stages still advance.
// Reset clears all valid bits and the origin registers to zero.
module point_rotate_about_y #(
	parameter int ROTATION_STAGES = pra_pkg::ROTATION_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pra_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pra_pkg::COORD_WIDTH-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  pra_pkg::point_req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output pra_pkg::point_rsp_t out_data
);
	import pra_pkg::*;

	logic signed [COORD_WIDTH-1:0] origin_x_q;
	logic signed [COORD_WIDTH-1:0] origin_z_q;

	side_t side_in;
	side_t side_rot;
	logic rot_valid;
	logic rot_ready;
	logic signed [TRIG_W-1:0] rot_cos;
	logic signed [TRIG_W-1:0] rot_sin;

	// origin_y has no effect on the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: ;
				REG_ORIGIN_Z: origin_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign side_in.dx = DIFF_W'(in_data.point_x) - DIFF_W'(origin_x_q);
	assign side_in.dz = DIFF_W'(in_data.point_z) - DIFF_W'(origin_z_q);
	assign side_in.py = in_data.point_y;

	pra_cordic #(
		.STAGES(ROTATION_STAGES)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_angle(in_data.angle),
		.in_side(side_in),
		.out_valid(rot_valid),
		.out_ready(rot_ready),
		.out_cos(rot_cos),
		.out_sin(rot_sin),
		.out_side(side_rot)
	);

	pra_rotate u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rot_valid),
		.in_ready(rot_ready),
		.in_cos(rot_cos),
		.in_sin(rot_sin),
		.in_side(side_rot),
		.origin_x(origin_x_q),
		.origin_z(origin_z_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
	import pra_pkg::*;

	localparam int LATENCY = ROTATION_STAGES + 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = COORD_MAX[COORD_WIDTH-1:0];
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = COORD_MIN[COORD_WIDTH-1:0];
	localparam logic [31:0] TURN_ATAN [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [COORD_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	point_req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	point_rsp_t out_data;

	logic signed [COORD_WIDTH-1:0] org_x = '0;
	logic signed [COORD_WIDTH-1:0] org_y = '0;
	logic signed [COORD_WIDTH-1:0] org_z = '0;

	point_rsp_t pending_points[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	point_rotate_about_y i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// round(a * b / 2^30), half away from zero
	function automatic longint mul_round(input longint a, input longint b);
		logic neg;
		logic [127:0] ua;
		logic [127:0] ub;
		logic [127:0] prod;
		longint mag;
		neg = (a < 0) != (b < 0);
		ua = 128'(a < 0 ? -a : a);
		ub = 128'(b < 0 ? -b : b);
		prod = (ua * ub + (128'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC;
		mag = longint'(prod[63:0]);
		return neg ? -mag : mag;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] clamp_coord(input longint v, inout logic hit);
		if (v > COORD_MAX) begin
			hit = 1'b1;
			return C_MAX;
		end
		if (v < COORD_MIN) begin
			hit = 1'b1;
			return C_MIN;
		end
		return v[COORD_WIDTH-1:0];
	endfunction

	function automatic point_rsp_t rotate_point(input point_req_t p);
		point_rsp_t r;
		logic [31:0] t;
		logic [1:0] quad;
		longint c;
		longint s;
		longint cs;
		longint ss;
		longint zr;
		longint cq;
		longint sq;
		longint dx;
		longint dz;
		logic hit;
		c = longint'(GAIN_Q30);
		s = 0;
		hit = 1'b0;
		t = (32'(p.angle) << (32 - ANGLE_WIDTH)) + EIGHTH_TURN;
		quad = t[31:30];
		zr = longint'({34'd0, t[29:0]}) - longint'({32'd0, EIGHTH_TURN});
		for (int i = 0; i < ROTATION_STAGES && i < 24; i++) begin
			cs = c >>> i;
			ss = s >>> i;
			if (zr >= 0) begin
				c = c - ss;
				s = s + cs;
				zr = zr - longint'({32'd0, TURN_ATAN[i]});
			end else begin
				c = c + ss;
				s = s - cs;
				zr = zr + longint'({32'd0, TURN_ATAN[i]});
			end
		end
		case (quad)
			2'd0: begin
				cq = c;
				sq = s;
			end
			2'd1: begin
				cq = -s;
				sq = c;
			end
			2'd2: begin
				cq = -c;
				sq = -s;
			end
			default: begin
				cq = s;
				sq = -c;
			end
		endcase
		dx = longint'(p.point_x) - longint'(org_x);
		dz = longint'(p.point_z) - longint'(org_z);
		r.rotated_x = clamp_coord(mul_round(dx, cq) - mul_round(dz, sq) + longint'(org_x), hit);
		r.rotated_z = clamp_coord(mul_round(dx, sq) + mul_round(dz, cq) + longint'(org_z), hit);
		r.rotated_y = p.point_y;
		r.saturated = hit;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] exp_v,
			input logic [COORD_WIDTH-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		point_rsp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$error("result with no request outstanding: %h", out_data);
				mismatches++;
			end else begin
				e = pending_points.pop_front();
				check_field("rotated_x", e.rotated_x, out_data.rotated_x);
				check_field("rotated_y", e.rotated_y, out_data.rotated_y);
				check_field("rotated_z", e.rotated_z, out_data.rotated_z);
				check_field("saturated", 32'(e.saturated), 32'(out_data.saturated));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// output side; a long hold-off is counted here
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_point(input point_req_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_points.push_back(rotate_point(p));
		@(negedge clk);
	endtask

	task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [15:0] a);
		point_req_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		p.angle = a;
		send_point(p);
	endtask

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_origin(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ORIGIN_X: org_x = val;
			REG_ORIGIN_Y: org_y = val;
			REG_ORIGIN_Z: org_z = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(1 << 20) - (1 << 19);
			2: begin
				case ($urandom_range(4))
					0: v = C_MAX;
					1: v = C_MIN;
					2: v = '0;
					3: v = '1;
					default: v = C_MAX - $urandom_range(255);
				endcase
			end
			default: v = {1'($urandom_range(1)), 31'($urandom)} ^ 32'h4000_0000;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] pick_angle();
		if ($urandom_range(4) == 0)
			return 16'($urandom_range(7)) * 16'h2000 + 16'($urandom_range(2)) - 16'd1;
		return 16'($urandom);
	endfunction

	task automatic test_directed_angles();
		send_xyz(32'h0001_0000, 32'h1234_5678, 32'h0002_0000, 16'h0000);
		send_xyz(32'h0001_0000, C_MAX, 32'h0002_0000, 16'h4000);
		send_xyz(32'h0001_0000, C_MIN, 32'h0002_0000, 16'h8000);
		send_xyz(32'h0001_0000, 32'h0, 32'h0002_0000, 16'hC000);
		send_xyz(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_8000, 16'hFFFF);
		send_xyz(32'h0010_0000, 32'h0000_0001, 32'hFFF0_0000, 16'h2000);
		send_xyz(32'h0010_0000, 32'h0, 32'hFFF0_0000, 16'h1FFF);
		send_xyz(32'h0, 32'h0, 32'h0, 16'h5555);
		send_xyz(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 16'h0001);
	endtask

	task automatic test_saturation();
		send_xyz(C_MAX, 32'h0, C_MAX, 16'h2000);
		send_xyz(C_MIN, 32'h0, C_MIN, 16'h6000);
		send_xyz(C_MAX, C_MIN, C_MIN, 16'hE000);
		send_xyz(C_MIN, C_MAX, C_MAX, 16'hA000);
		send_xyz(C_MIN, 32'h0, C_MIN, 16'h0000);
		settle_pipeline();
	endtask

	task automatic test_origin_registers();
		write_origin(REG_ORIGIN_X, C_MIN);
		write_origin(REG_ORIGIN_Y, C_MAX);
		write_origin(REG_ORIGIN_Z, C_MAX);
		// out-of-range index must leave the origin alone
		write_origin(REG_UNUSED, $urandom);
		send_xyz(C_MAX, 32'h0, C_MIN, 16'h8000);
		send_xyz(C_MIN, 32'h0, C_MAX, 16'h0000);
		send_xyz(32'h0, 32'h0, 32'h0, 16'h4000);
		send_xyz(C_MAX, 32'hABCD_0000, C_MAX, 16'h3000);
		settle_pipeline();
	endtask

	task automatic test_backpressure();
		write_origin(REG_ORIGIN_X, 32'h0003_0000);
		write_origin(REG_ORIGIN_Z, 32'hFFFD_0000);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 300;
		repeat (100)
			send_xyz(pick_coord(), pick_coord(), pick_coord(), pick_angle());
		settle_pipeline();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		case ($urandom_range(3))
			0: begin
				write_origin(REG_ORIGIN_X, $urandom);
				write_origin(REG_ORIGIN_Y, $urandom);
				write_origin(REG_ORIGIN_Z, $urandom);
			end
			1: begin
				write_origin(REG_ORIGIN_X, C_MAX);
				write_origin(REG_ORIGIN_Y, C_MIN);
				write_origin(REG_ORIGIN_Z, C_MIN);
			end
			2: begin
				write_origin(REG_ORIGIN_X, '0);
				write_origin(REG_ORIGIN_Y, '0);
				write_origin(REG_ORIGIN_Z, '0);
			end
			default: begin
				write_origin(REG_ORIGIN_X, pick_coord());
				write_origin(REG_ORIGIN_Y, pick_coord());
				write_origin(REG_ORIGIN_Z, pick_coord());
			end
		endcase
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_xyz(pick_coord(), pick_coord(), pick_coord(), pick_angle());
		settle_pipeline();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_angles();
		test_saturation();
		test_origin_registers();
		test_backpressure();
		test_random_traffic(0, 0, 160);
		test_random_traffic(51, 0, 160);
		test_random_traffic(0, 51, 160);
		test_random_traffic(34, 34, 160);
		recv_stall_pct = 0;
		settle_pipeline();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
